/* hdl/voxel_face_culling_mesher_assert.svh */
// ----------------------------------------------------------------------------
// voxel_face_culling_mesher_assert
// Assertion macros shared by the mesher rtl.
// ----------------------------------------------------------------------------

`ifndef VOXEL_FACE_CULLING_MESHER_ASSERT_SVH
`define VOXEL_FACE_CULLING_MESHER_ASSERT_SVH

// clocked check, masked while reset is high
`define VFCM_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// clocked check that also covers the reset cycles
`define VFCM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) \
      else $error(msg);

`endif

/* hdl/vfcm_pkg.sv */
// ----------------------------------------------------------------------------
// vfcm_pkg
// Field widths, block and face codes and the atlas tile lookup of the voxel
// face culling mesher.
// ----------------------------------------------------------------------------
package vfcm_pkg;

   localparam int CELL_XW  = 4;
   localparam int CELL_YW  = 8;
   localparam int BLOCK_W  = 3;
   localparam int FACE_XW  = 5;
   localparam int FACE_YW  = 9;
   localparam int VBASE_W  = 21;
   localparam int FCOUNT_W = VBASE_W - 2;   // four vertices per face

   // neighbor coordinates with headroom so that minus one wraps far above
   // any chunk size
   localparam int NBR_XW = 7;
   localparam int NBR_YW = 10;

   // request mode codes
   localparam logic MODE_WRITE = 1'b0;
   localparam logic MODE_QUERY = 1'b1;

   typedef enum logic [2:0] {
      BLK_AIR   = 3'd0,
      BLK_DIRT  = 3'd1,
      BLK_GRASS = 3'd2,
      BLK_STONE = 3'd3,
      BLK_WATER = 3'd4,
      BLK_SAND  = 3'd5,
      BLK_OAK   = 3'd6,
      BLK_OTHER = 3'd7
   } block_kind_type;

   typedef enum logic [2:0] {
      DIR_NEG_Z = 3'd0,
      DIR_POS_Z = 3'd1,
      DIR_NEG_X = 3'd2,
      DIR_POS_X = 3'd3,
      DIR_NEG_Y = 3'd4,
      DIR_POS_Y = 3'd5
   } dir_type;

   typedef struct packed {
      logic [1:0] col;
      logic       row;
   } tile_type;

   function automatic tile_type tile_of(input block_kind_type blk, input dir_type dir);
      tile_type t;
      logic     top;
      logic     bottom;
      t      = '0;
      top    = (dir == DIR_POS_Y);
      bottom = (dir == DIR_NEG_Y);
      unique case (blk)
         BLK_DIRT:  t.row = 1'b1;
         BLK_GRASS: begin
            if (bottom) begin
               t.row = 1'b1;
            end else if (!top) begin
               t.col = 2'd1;
            end
         end
         BLK_STONE: begin
            t.col = 2'd1;
            t.row = 1'b1;
         end
         BLK_WATER: t.col = 2'd3;
         BLK_SAND:  t.col = 2'd2;
         BLK_OAK: begin
            t.row = 1'b1;
            t.col = (top || bottom) ? 2'd3 : 2'd2;
         end
         default: t = '0;
      endcase
      return t;
   endfunction

endpackage

/* hdl/vfcm_ram.sv */
// ----------------------------------------------------------------------------
// vfcm_ram
// Generic single write port, single read port ram with registered read data.
// ----------------------------------------------------------------------------
module vfcm_ram #(
   parameter int WIDTH = 3,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] ram_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         ram_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= ram_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/voxel_face_culling_mesher.sv */
// ----------------------------------------------------------------------------
// voxel_face_culling_mesher
// Stores block types of one chunk and emits the exposed faces of a cell.
// ----------------------------------------------------------------------------
// A write beat stores one cell's block type. A query beat reads the cell and
// its six neighbors one after the other through the single read port of the
// cell ram, whose read data is registered, and then hands out one face per
// cycle while the response side does not stall, in the order -z, +z, -x, +x,
// -y, +y. A query of a cell that shows no face emits nothing, and a query
// outside the chunk emits no face and leaves the block idle. After reset the
// block sweeps every address of the cell ram to air, one cell a cycle, and
// stalls the request side meanwhile. A face may wait in the response register
// while the next request is taken.
`include "voxel_face_culling_mesher_assert.svh"

module voxel_face_culling_mesher #(
   parameter int CHUNK_WIDTH = 16,
   parameter int CHUNK_TALL  = 256
) (
   input  logic                            clock,
   input  logic                            reset,

   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_mode,
   input  logic [vfcm_pkg::CELL_XW-1:0]    req_cell_x,
   input  logic [vfcm_pkg::CELL_YW-1:0]    req_cell_y,
   input  logic [vfcm_pkg::CELL_XW-1:0]    req_cell_z,
   input  logic [vfcm_pkg::BLOCK_W-1:0]    req_block_type,
   input  logic                            req_first_cell,

   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [vfcm_pkg::FACE_XW-1:0]    rsp_face_x,
   output logic [vfcm_pkg::FACE_YW-1:0]    rsp_face_y,
   output logic [vfcm_pkg::FACE_XW-1:0]    rsp_face_z,
   output vfcm_pkg::dir_type               rsp_face_dir,
   output logic [1:0]                      rsp_tile_col,
   output logic                            rsp_tile_row,
   output logic [vfcm_pkg::VBASE_W-1:0]    rsp_vertex_base,
   output logic                            rsp_last_face
);

   import vfcm_pkg::*;

   // only coordinates that the request fields can reach get storage
   localparam int XDIM  = (CHUNK_WIDTH < (1 << CELL_XW)) ? CHUNK_WIDTH : (1 << CELL_XW);
   localparam int YDIM  = (CHUNK_TALL < (1 << CELL_YW)) ? CHUNK_TALL : (1 << CELL_YW);
   localparam int XB    = $clog2(XDIM);
   localparam int YB    = $clog2(YDIM);
   localparam int AW    = 2 * XB + YB;
   localparam int DEPTH = 1 << AW;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_EMIT
   } state_type;

   state_type              state_ff, state_in;
   logic [AW-1:0]          clr_addr_ff, clr_addr_in;
   logic [2:0]             step_ff, step_in;
   logic [CELL_XW-1:0]     x_ff, x_in;
   logic [CELL_YW-1:0]     y_ff, y_in;
   logic [CELL_XW-1:0]     z_ff, z_in;
   block_kind_type         type_ff, type_in;
   logic [5:0]             exposed_ff, exposed_in;
   logic [FCOUNT_W-1:0]    cnt_ff, cnt_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [FACE_XW-1:0]     face_x_ff, face_x_in;
   logic [FACE_YW-1:0]     face_y_ff, face_y_in;
   logic [FACE_XW-1:0]     face_z_ff, face_z_in;
   dir_type                dir_ff, dir_in;
   tile_type               tile_ff, tile_in;
   logic [VBASE_W-1:0]     vbase_ff, vbase_in;
   logic                   last_ff, last_in;

   logic                   req_fire;
   logic                   req_inside;
   logic                   ram_we;
   logic [AW-1:0]          ram_wa;
   logic [BLOCK_W-1:0]     ram_wd;
   logic [AW-1:0]          ram_ra;
   logic [BLOCK_W-1:0]     ram_rd;
   logic                   face_load;
   logic [AW:0]            issue_nbr;
   logic [AW:0]            check_nbr;
   logic [5:0]             cand;
   logic [5:0]             remain;
   dir_type                pick;

   // msb: neighbor lies in stored cells, rest: its ram address
   // cells of the chunk beyond the reachable coordinates are always air
   function automatic logic [AW:0] nbr_lookup(input logic [CELL_XW-1:0] cx,
                                              input logic [CELL_YW-1:0] cy,
                                              input logic [CELL_XW-1:0] cz,
                                              input dir_type            dir);
      logic [NBR_XW-1:0] nx;
      logic [NBR_YW-1:0] ny;
      logic [NBR_XW-1:0] nz;
      logic              ok;
      nx = NBR_XW'(cx);
      ny = NBR_YW'(cy);
      nz = NBR_XW'(cz);
      unique case (dir)
         DIR_NEG_Z: nz = nz - 1'b1;
         DIR_POS_Z: nz = nz + 1'b1;
         DIR_NEG_X: nx = nx - 1'b1;
         DIR_POS_X: nx = nx + 1'b1;
         DIR_NEG_Y: ny = ny - 1'b1;
         DIR_POS_Y: ny = ny + 1'b1;
         default: ;
      endcase
      ok = (32'(nx) < XDIM) && (32'(ny) < YDIM) && (32'(nz) < XDIM);
      return {ok, nx[XB-1:0], ny[YB-1:0], nz[XB-1:0]};
   endfunction

   vfcm_ram #(
      .WIDTH (BLOCK_W),
      .DEPTH (DEPTH)
   ) u_cell_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wa),
      .wr_data (ram_wd),
      .rd_addr (ram_ra),
      .rd_data (ram_rd)
   );

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_fire   = req_valid && !req_stall;
   assign req_inside = (32'(req_cell_x) < CHUNK_WIDTH) && (32'(req_cell_y) < CHUNK_TALL) &&
                       (32'(req_cell_z) < CHUNK_WIDTH);

   // clearing sweep owns the write port until it is done
   always_comb begin
      if (state_ff == ST_CLEAR) begin
         ram_we = 1'b1;
         ram_wa = clr_addr_ff;
         ram_wd = BLK_AIR;
      end else begin
         ram_we = req_fire && (req_mode == MODE_WRITE) && req_inside;
         ram_wa = {req_cell_x[XB-1:0], req_cell_y[YB-1:0], req_cell_z[XB-1:0]};
         ram_wd = req_block_type;
      end
   end

   // step 0 reads the cell itself, steps 1 to 6 its neighbors
   assign issue_nbr = nbr_lookup(x_ff, y_ff, z_ff, dir_type'(step_ff - 3'd1));
   assign check_nbr = nbr_lookup(x_ff, y_ff, z_ff, dir_type'(step_ff - 3'd2));
   assign ram_ra    = (step_ff == 3'd0) ? {x_ff[XB-1:0], y_ff[YB-1:0], z_ff[XB-1:0]}
                                        : issue_nbr[AW-1:0];

   assign cand = (type_ff != BLK_AIR) ? exposed_ff : 6'b0;

   always_comb begin
      pick = DIR_NEG_Z;
      for (int i = 5; i >= 0; i--) begin
         if (cand[i]) begin
            pick = dir_type'(i);
         end
      end
   end

   assign remain    = cand & ~(6'b1 << pick);
   assign face_load = (state_ff == ST_EMIT) && (cand != 6'b0) &&
                      (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      step_in      = step_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      z_in         = z_ff;
      type_in      = type_ff;
      exposed_in   = exposed_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      face_x_in    = face_x_ff;
      face_y_in    = face_y_ff;
      face_z_in    = face_z_ff;
      dir_in       = dir_ff;
      tile_in      = tile_ff;
      vbase_in     = vbase_ff;
      last_in      = last_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == {AW{1'b1}}) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire && (req_mode == MODE_QUERY)) begin
               if (req_first_cell) begin
                  cnt_in = '0;
               end
               x_in    = req_cell_x;
               y_in    = req_cell_y;
               z_in    = req_cell_z;
               step_in = 3'd0;
               if (req_inside) begin
                  state_in = ST_READ;
               end
            end
         end
         ST_READ: begin
            step_in = step_ff + 3'd1;
            if (step_ff == 3'd1) begin
               type_in = block_kind_type'(ram_rd);
            end else if (step_ff != 3'd0) begin
               exposed_in[step_ff - 3'd2] = !check_nbr[AW] || (ram_rd == BLK_AIR);
            end
            if (step_ff == 3'd7) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (cand == 6'b0) begin
               state_in = ST_IDLE;
            end else if (face_load) begin
               rsp_valid_in = 1'b1;
               face_x_in    = FACE_XW'(x_ff) + FACE_XW'(pick == DIR_POS_X);
               face_y_in    = FACE_YW'(y_ff) + FACE_YW'(pick == DIR_POS_Y);
               face_z_in    = FACE_XW'(z_ff) + FACE_XW'(pick == DIR_POS_Z);
               dir_in       = pick;
               tile_in      = tile_of(type_ff, pick);
               vbase_in     = {cnt_ff, 2'b00};
               last_in      = (remain == 6'b0);
               cnt_in       = cnt_ff + 1'b1;
               exposed_in   = remain;
               if (remain == 6'b0) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         step_ff      <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         step_ff      <= step_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      x_ff       <= x_in;
      y_ff       <= y_in;
      z_ff       <= z_in;
      type_ff    <= type_in;
      exposed_ff <= exposed_in;
      face_x_ff  <= face_x_in;
      face_y_ff  <= face_y_in;
      face_z_ff  <= face_z_in;
      dir_ff     <= dir_in;
      tile_ff    <= tile_in;
      vbase_ff   <= vbase_in;
      last_ff    <= last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_face_x      = face_x_ff;
   assign rsp_face_y      = face_y_ff;
   assign rsp_face_z      = face_z_ff;
   assign rsp_face_dir    = dir_ff;
   assign rsp_tile_col    = tile_ff.col;
   assign rsp_tile_row    = tile_ff.row;
   assign rsp_vertex_base = vbase_ff;
   assign rsp_last_face   = last_ff;

   `VFCM_ASSERT_ALWAYS(a_reset_starts_sweep, clock,
      reset |=> (state_ff == ST_CLEAR && !rsp_valid_ff && cnt_ff == '0),
      "reset did not start the clearing sweep")
   `VFCM_ASSERT(a_quiet_while_clearing, clock, reset,
      (state_ff == ST_CLEAR) |-> (req_stall && !rsp_valid_ff),
      "traffic during the clearing sweep")
   `VFCM_ASSERT(a_face_from_solid, clock, reset,
      face_load |-> (type_ff != BLK_AIR),
      "face emitted for an air cell")
   `VFCM_ASSERT(a_face_advances_count, clock, reset,
      face_load |=> (cnt_ff == $past(cnt_ff) + 1'b1),
      "vertex count did not advance by one face")
   `VFCM_ASSERT(a_top_face_is_last, clock, reset,
      (rsp_valid_ff && dir_ff == DIR_POS_Y) |-> last_ff,
      "+y face not flagged as last")

endmodule
